// ----- rtl/dgsa_pkg.sv -----
// Shared types and codes for the directed graph store and analysis core.
package dgsa_pkg;

    typedef enum logic [1:0] {
        CMD_ADD_NODE = 2'd0,
        CMD_ADD_EDGE = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_ANALYZE  = 2'd3
    } t_cmd;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_ADD,
        OP_FAIL,
        OP_EDGE_RD,
        OP_EDGE_DO,
        OP_RM_RD,
        OP_RM_DO,
        OP_AN_INIT,
        OP_DEG_RD,
        OP_DEG_DO,
        OP_MAXIN,
        OP_REL_RD,
        OP_REL_DO,
        OP_ROUND,
        OP_EMIT_RD,
        OP_EMIT_LD,
        OP_NEXT
    } t_op;

    // Datapath status seen by the controller
    typedef struct packed {
        t_cmd cmd;
        logic rm_bad;
        logic empty;
        logic idx_last;
        logic round_last;
        logic changed;
        logic res_last;
    } t_sts;

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_DISP    = 16'h0002,
        S_EDGE_RD = 16'h0004,
        S_EDGE_DO = 16'h0008,
        S_RM_RD   = 16'h0010,
        S_RM_DO   = 16'h0020,
        S_AN_INIT = 16'h0040,
        S_DEG_RD  = 16'h0080,
        S_DEG_DO  = 16'h0100,
        S_MAXIN   = 16'h0200,
        S_REL_RD  = 16'h0400,
        S_REL_DO  = 16'h0800,
        S_ROUND   = 16'h1000,
        S_EMIT_RD = 16'h2000,
        S_EMIT_LD = 16'h4000,
        S_OUT     = 16'h8000
    } t_state;

    localparam logic [1:0] VC_PRODUCER  = 2'd0;
    localparam logic [1:0] VC_HERBIVORE = 2'd1;
    localparam logic [1:0] VC_OMNIVORE  = 2'd2;
    localparam logic [1:0] VC_CARNIVORE = 2'd3;

endpackage

// ----- rtl/dgsa_datapath.sv -----
// Datapath: adjacency memory, degree counters, height lanes and result register.
module dgsa_datapath import dgsa_pkg::*; #(
    parameter int MAX_NODES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_op        i_op,
    input  logic [1:0] i_cmd,
    input  logic [3:0] i_first_index,
    input  logic [3:0] i_second_index,
    input  logic       i_out_stall,
    output t_sts       o_sts,
    output logic       o_out_valid,
    output logic       o_ok,
    output logic [3:0] o_node_index,
    output logic [3:0] o_out_degree,
    output logic [3:0] o_in_degree,
    output logic       o_is_apex,
    output logic       o_is_producer,
    output logic       o_most_flexible,
    output logic       o_tastiest,
    output logic [3:0] o_height,
    output logic [1:0] o_vore_class,
    output logic       o_height_unsettled,
    output logic       o_last
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int XW = AW + 5;
    localparam int TN = 1 << AW;

    // Command fields and counters
    t_cmd                 r_cmd;
    logic [3:0]           r_a;
    logic [3:0]           r_b;
    logic [AW:0]          r_count;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        r_round;
    logic                 r_changed;

    // Adjacency memory with registered read
    logic [MAX_NODES-1:0] mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_rd;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [MAX_NODES-1:0] wdata;
    logic [AW-1:0]        raddr;

    // Per-node lanes
    logic [CW-1:0]        r_outd [MAX_NODES];
    logic [CW-1:0]        r_ind  [MAX_NODES];
    logic [3:0]           r_h    [MAX_NODES];
    logic [MAX_NODES-1:0] r_prod;
    logic [CW-1:0]        r_max_out;
    logic [CW-1:0]        r_max_in;

    // Result register
    logic                 r_valid;
    logic                 r_ok;
    logic [3:0]           r_node;
    logic [3:0]           r_outdeg;
    logic [3:0]           r_indeg;
    logic                 r_apex;
    logic                 r_producer;
    logic                 r_flex;
    logic                 r_tasty;
    logic [3:0]           r_height;
    logic [1:0]           r_class;
    logic                 r_unsettled;
    logic                 r_last;

    logic [XW-1:0]        a_x, b_x, cnt_x, idx_x, lim_x, cnt16_x;
    logic [AW-1:0]        a_addr, b_addr, rm_src;
    logic                 edge_bad;
    logic [MAX_NODES-1:0] low, compressed, bit_b;
    logic [CW-1:0]        pop;
    logic [3:0]           tree [1:2*TN-1];
    logic [3:0]           best;
    logic                 eats_prod, eats_non;
    logic [1:0]           cls;
    logic [AW+3:0]        idx_n;

    function automatic logic [3:0] sat4(input logic [CW-1:0] v);
        logic [CW+3:0] w;
        w = (CW+4)'(v);
        return (w > (CW+4)'(15)) ? 4'd15 : w[3:0];
    endfunction

    // Compare and address helpers
    always_comb begin
        a_x     = XW'(r_a);
        b_x     = XW'(r_b);
        cnt_x   = XW'(r_count);
        idx_x   = XW'(r_idx);
        cnt16_x = XW'(16);
        a_addr  = a_x[AW-1:0];
        b_addr  = b_x[AW-1:0];
        lim_x   = (cnt_x > cnt16_x) ? XW'(15) : cnt_x - XW'(1);
        rm_src  = (idx_x >= a_x) ? r_idx + AW'(1) : r_idx;
        edge_bad = (a_x >= cnt_x) || (b_x >= cnt_x) || (r_a == r_b) || r_rd[b_addr];
        bit_b   = MAX_NODES'(1) << b_addr;
        low     = (MAX_NODES'(1) << a_addr) - MAX_NODES'(1);
        compressed = (r_rd & low) | ((r_rd >> 1) & ~low);
        pop     = CW'($countones(r_rd));
        idx_n   = (AW+4)'(r_idx);
    end

    // Max over target heights plus one, as a tree
    always_comb begin
        for (int j = 0; j < TN; j++) begin
            if (j < MAX_NODES && r_rd[j]) begin
                tree[TN+j] = (r_h[j] == 4'd15) ? 4'd15 : r_h[j] + 4'd1;
            end else begin
                tree[TN+j] = 4'd0;
            end
        end
        for (int k = TN - 1; k >= 1; k--) begin
            tree[k] = (tree[2*k] > tree[2*k+1]) ? tree[2*k] : tree[2*k+1];
        end
        best = tree[1];
    end

    // Class of the node on the read row
    always_comb begin
        eats_prod = |(r_rd & r_prod);
        eats_non  = |(r_rd & ~r_prod);
        if (r_outd[r_idx] == '0) begin
            cls = VC_PRODUCER;
        end else if (eats_prod && eats_non) begin
            cls = VC_OMNIVORE;
        end else if (eats_prod) begin
            cls = VC_HERBIVORE;
        end else begin
            cls = VC_CARNIVORE;
        end
    end

    // Memory port selection
    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = '0;
        raddr = r_idx;
        case (i_op)
            OP_ADD: begin
                we    = (cnt_x < XW'(MAX_NODES));
                waddr = r_count[AW-1:0];
            end
            OP_EDGE_RD: begin
                raddr = a_addr;
            end
            OP_EDGE_DO: begin
                we    = !edge_bad;
                waddr = a_addr;
                wdata = r_rd | bit_b;
            end
            OP_RM_RD: begin
                raddr = rm_src;
            end
            OP_RM_DO: begin
                we    = 1'b1;
                wdata = o_sts.idx_last ? '0 : compressed;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[raddr];
    end

    // Status toward the controller
    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.rm_bad     = (a_x >= cnt_x);
        o_sts.empty      = (r_count == '0);
        o_sts.idx_last   = (idx_x + XW'(1) == cnt_x);
        o_sts.round_last = (r_round == AW'(MAX_NODES - 1));
        o_sts.changed    = r_changed;
        o_sts.res_last   = r_last;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            case (i_op)
                OP_ADD: begin
                    if (cnt_x < XW'(MAX_NODES)) begin
                        r_count <= r_count + (AW+1)'(1);
                    end
                    r_valid <= 1'b1;
                end
                OP_FAIL, OP_EDGE_DO, OP_EMIT_LD: begin
                    r_valid <= 1'b1;
                end
                OP_RM_DO: begin
                    if (o_sts.idx_last) begin
                        r_count <= r_count - (AW+1)'(1);
                        r_valid <= 1'b1;
                    end
                end
                default: begin
                    r_valid <= r_valid && i_out_stall;
                end
            endcase
        end
    end

    // Work registers and result payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_ACCEPT: begin
                r_cmd <= t_cmd'(i_cmd);
                r_a   <= i_first_index;
                r_b   <= i_second_index;
                r_idx <= '0;
            end
            OP_ADD: begin
                r_ok   <= (cnt_x < XW'(MAX_NODES));
                r_node <= (cnt_x < XW'(MAX_NODES)) ? cnt_x[3:0] : 4'd0;
                r_outdeg <= '0; r_indeg <= '0; r_apex <= 1'b0; r_producer <= 1'b0;
                r_flex <= 1'b0; r_tasty <= 1'b0; r_height <= '0; r_class <= VC_PRODUCER;
                r_unsettled <= 1'b0; r_last <= 1'b1;
            end
            OP_FAIL: begin
                r_ok <= 1'b0; r_node <= '0;
                r_outdeg <= '0; r_indeg <= '0; r_apex <= 1'b0; r_producer <= 1'b0;
                r_flex <= 1'b0; r_tasty <= 1'b0; r_height <= '0; r_class <= VC_PRODUCER;
                r_unsettled <= 1'b0; r_last <= 1'b1;
            end
            OP_EDGE_DO: begin
                r_ok <= !edge_bad; r_node <= '0;
                r_outdeg <= '0; r_indeg <= '0; r_apex <= 1'b0; r_producer <= 1'b0;
                r_flex <= 1'b0; r_tasty <= 1'b0; r_height <= '0; r_class <= VC_PRODUCER;
                r_unsettled <= 1'b0; r_last <= 1'b1;
            end
            OP_RM_DO: begin
                r_idx <= o_sts.idx_last ? '0 : r_idx + AW'(1);
                r_ok <= 1'b1; r_node <= '0;
                r_outdeg <= '0; r_indeg <= '0; r_apex <= 1'b0; r_producer <= 1'b0;
                r_flex <= 1'b0; r_tasty <= 1'b0; r_height <= '0; r_class <= VC_PRODUCER;
                r_unsettled <= 1'b0; r_last <= 1'b1;
            end
            OP_AN_INIT: begin
                r_idx     <= '0;
                r_round   <= '0;
                r_changed <= 1'b0;
                r_max_out <= '0;
                r_max_in  <= '0;
                for (int j = 0; j < MAX_NODES; j++) begin
                    r_ind[j] <= '0;
                    r_h[j]   <= '0;
                end
            end
            OP_DEG_DO: begin
                r_outd[r_idx] <= pop;
                r_prod[r_idx] <= (pop == '0);
                if (pop > r_max_out) begin
                    r_max_out <= pop;
                end
                for (int j = 0; j < MAX_NODES; j++) begin
                    r_ind[j] <= r_ind[j] + CW'(r_rd[j]);
                end
                r_idx <= o_sts.idx_last ? '0 : r_idx + AW'(1);
            end
            OP_MAXIN: begin
                if (r_ind[r_idx] > r_max_in) begin
                    r_max_in <= r_ind[r_idx];
                end
                r_idx <= o_sts.idx_last ? '0 : r_idx + AW'(1);
            end
            OP_REL_DO: begin
                if (best > r_h[r_idx]) begin
                    r_h[r_idx] <= best;
                    r_changed  <= 1'b1;
                end
                r_idx <= o_sts.idx_last ? '0 : r_idx + AW'(1);
            end
            OP_ROUND: begin
                r_round   <= r_round + AW'(1);
                r_changed <= 1'b0;
            end
            OP_EMIT_LD: begin
                r_ok        <= 1'b1;
                r_node      <= idx_n[3:0];
                r_outdeg    <= sat4(r_outd[r_idx]);
                r_indeg     <= sat4(r_ind[r_idx]);
                r_apex      <= (r_ind[r_idx] == '0);
                r_producer  <= (r_outd[r_idx] == '0);
                r_flex      <= (r_outd[r_idx] == r_max_out);
                r_tasty     <= (r_ind[r_idx] == r_max_in);
                r_height    <= r_h[r_idx];
                r_class     <= cls;
                r_unsettled <= r_changed;
                r_last      <= (idx_x == lim_x);
            end
            OP_NEXT: begin
                r_idx <= r_idx + AW'(1);
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    assign o_out_valid        = r_valid;
    assign o_ok               = r_ok;
    assign o_node_index       = r_node;
    assign o_out_degree       = r_outdeg;
    assign o_in_degree        = r_indeg;
    assign o_is_apex          = r_apex;
    assign o_is_producer      = r_producer;
    assign o_most_flexible    = r_flex;
    assign o_tastiest         = r_tasty;
    assign o_height           = r_height;
    assign o_vore_class       = r_class;
    assign o_height_unsettled = r_unsettled;
    assign o_last             = r_last;

endmodule

// ----- rtl/dgsa_ctrl.sv -----
// Controller state machine: sequences commands through the datapath.
module dgsa_ctrl import dgsa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_op  o_op
);

    t_state r_state;
    t_state n_state;

    // Next state and datapath operation
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_ACCEPT;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.cmd)
                    CMD_ADD_NODE: begin
                        o_op    = OP_ADD;
                        n_state = S_OUT;
                    end
                    CMD_ADD_EDGE: begin
                        n_state = S_EDGE_RD;
                    end
                    CMD_REMOVE: begin
                        if (i_sts.rm_bad) begin
                            o_op    = OP_FAIL;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_RM_RD;
                        end
                    end
                    default: begin
                        if (i_sts.empty) begin
                            o_op    = OP_FAIL;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_AN_INIT;
                        end
                    end
                endcase
            end
            S_EDGE_RD: begin
                o_op    = OP_EDGE_RD;
                n_state = S_EDGE_DO;
            end
            S_EDGE_DO: begin
                o_op    = OP_EDGE_DO;
                n_state = S_OUT;
            end
            S_RM_RD: begin
                o_op    = OP_RM_RD;
                n_state = S_RM_DO;
            end
            S_RM_DO: begin
                o_op    = OP_RM_DO;
                n_state = i_sts.idx_last ? S_OUT : S_RM_RD;
            end
            S_AN_INIT: begin
                o_op    = OP_AN_INIT;
                n_state = S_DEG_RD;
            end
            S_DEG_RD: begin
                o_op    = OP_DEG_RD;
                n_state = S_DEG_DO;
            end
            S_DEG_DO: begin
                o_op    = OP_DEG_DO;
                n_state = i_sts.idx_last ? S_MAXIN : S_DEG_RD;
            end
            S_MAXIN: begin
                o_op    = OP_MAXIN;
                n_state = i_sts.idx_last ? S_REL_RD : S_MAXIN;
            end
            S_REL_RD: begin
                o_op    = OP_REL_RD;
                n_state = S_REL_DO;
            end
            S_REL_DO: begin
                o_op    = OP_REL_DO;
                n_state = i_sts.idx_last ? S_ROUND : S_REL_RD;
            end
            S_ROUND: begin
                // stop once a round changes nothing or the round limit is hit
                if (!i_sts.changed || i_sts.round_last) begin
                    n_state = S_EMIT_RD;
                end else begin
                    o_op    = OP_ROUND;
                    n_state = S_REL_RD;
                end
            end
            S_EMIT_RD: begin
                o_op    = OP_EMIT_RD;
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                o_op    = OP_EMIT_LD;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (i_sts.res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_op    = OP_NEXT;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/directed_graph_store_and_analysis_core.sv -----
// Top level: directed graph store with degree and longest-path analysis.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------
//  request  | i_in_valid / o_in_stall  | i_cmd, i_first_index, i_second_index
//  result   | o_out_valid / i_out_stall| o_ok ... o_last (one or more per request)
//
// One request is handled at a time; o_in_stall is high from acceptance until the
// last result is taken. Remove and analyze step through the adjacency rows, each row read
// in its own state before use; analyze runs R relaxation rounds (<= MAX_NODES) and reads
// a row again for each result, from the adjacency memory with its registered read port.
// Reset is synchronous and active low; it empties the graph without a clearing pass.
// A stalled result holds in the output register until taken.
module directed_graph_store_and_analysis_core import dgsa_pkg::*; #(
    parameter int MAX_NODES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [3:0] i_first_index,
    input  logic [3:0] i_second_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_ok,
    output logic [3:0] o_node_index,
    output logic [3:0] o_out_degree,
    output logic [3:0] o_in_degree,
    output logic       o_is_apex,
    output logic       o_is_producer,
    output logic       o_most_flexible,
    output logic       o_tastiest,
    output logic [3:0] o_height,
    output logic [1:0] o_vore_class,
    output logic       o_height_unsettled,
    output logic       o_last
);

    t_op  op;
    t_sts sts;

    dgsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_op        (op)
    );

    dgsa_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_op               (op),
        .i_cmd              (i_cmd),
        .i_first_index      (i_first_index),
        .i_second_index     (i_second_index),
        .i_out_stall        (i_out_stall),
        .o_sts              (sts),
        .o_out_valid        (o_out_valid),
        .o_ok               (o_ok),
        .o_node_index       (o_node_index),
        .o_out_degree       (o_out_degree),
        .o_in_degree        (o_in_degree),
        .o_is_apex          (o_is_apex),
        .o_is_producer      (o_is_producer),
        .o_most_flexible    (o_most_flexible),
        .o_tastiest         (o_tastiest),
        .o_height           (o_height),
        .o_vore_class       (o_vore_class),
        .o_height_unsettled (o_height_unsettled),
        .o_last             (o_last)
    );

    // A pending result always blocks new requests
    a_valid_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result pending while requests are open");

    // Taking the last result frees the request side
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last && !i_out_stall |=> !o_in_stall && !o_out_valid)
        else $error("request side not freed after last result");

    // A rejected request gives exactly one result
    a_fail_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_last)
        else $error("rejected request with more than one result");

endmodule
